// ----- sv/lock_and_condition_server_core_macros.svh -----
// Assertion macros used by the lock and condition server back end
`ifndef LOCK_AND_CONDITION_SERVER_CORE_MACROS_SVH
`define LOCK_AND_CONDITION_SERVER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LACS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LACS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LACS_ASSERT(lbl, prop, msg)
`define LACS_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- sv/lacs_pkg.sv -----
// Types, codes and sizes of the lock and condition server
package lacs_pkg;

  localparam int LOCK_SLOTS  = 128;
  localparam int COND_SLOTS  = 128;
  localparam int QUEUE_DEPTH = 8;
  localparam int NODE_BITS   = 8;
  localparam int NAME_CHARS  = 14;

  localparam int LB        = $clog2(LOCK_SLOTS);
  localparam int CIB       = $clog2(COND_SLOTS);
  localparam int SCAN_BITS = (LB > CIB) ? LB : CIB;
  localparam int QB        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTB      = $clog2(QUEUE_DEPTH + 1);
  localparam int LWQ_DEPTH = LOCK_SLOTS * QUEUE_DEPTH;
  localparam int CWQ_DEPTH = COND_SLOTS * QUEUE_DEPTH;
  localparam int LWA       = $clog2(LWQ_DEPTH);
  localparam int CWA       = $clog2(CWQ_DEPTH);

  typedef enum logic [2:0] {
    CMD_CREATE_LOCK  = 3'd0,
    CMD_DESTROY_LOCK = 3'd1,
    CMD_ACQUIRE      = 3'd2,
    CMD_RELEASE      = 3'd3,
    CMD_CREATE_COND  = 3'd4,
    CMD_DESTROY_COND = 3'd5,
    CMD_SIGNAL       = 3'd6,
    CMD_WAIT         = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_WAIT    = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  localparam logic KIND_LOCK = 1'b0;
  localparam logic KIND_COND = 1'b1;

  typedef struct packed {
    cmd_t                 cmd;
    logic [NODE_BITS-1:0] req;
    logic [55:0]          hi;
    logic [55:0]          lo;
    logic [6:0]           li;
    logic [6:0]           ci;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] slot;
    logic       nv;
    logic       nk;
    logic [7:0] nt;
  } res_t;

  typedef struct packed {
    logic [55:0]          hi;
    logic [55:0]          lo;
    logic                 owned;
    logic [NODE_BITS-1:0] owner;
    logic [QB-1:0]        head;
    logic [CNTB-1:0]      count;
  } lrow_t;

  typedef struct packed {
    logic [55:0]     hi;
    logic [55:0]     lo;
    logic [QB-1:0]   head;
    logic [CNTB-1:0] count;
  } crow_t;

endpackage

// ----- sv/lacs_ram.sv -----
// Generic simple dual-port RAM with registered read
module lacs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- sv/lacs_front.sv -----
// Front end: accepts request words, tidies names, queues them for the back end
module lacs_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [2:0]                      in_command,
  input  logic [7:0]                      in_requester,
  input  logic [55:0]                     in_name_high,
  input  logic [55:0]                     in_name_low,
  input  logic [6:0]                      in_lock_index,
  input  logic [6:0]                      in_cond_index,
  output logic                            fr_vld,
  output lacs_pkg::item_t                 fr_item,
  input  logic                            fr_take
);

  lacs_pkg::item_t q_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  lacs_pkg::item_t it_in;
  logic [111:0]    nm_tidy;
  logic            acc;

  function automatic logic [111:0] tidy(input logic [55:0] h, input logic [55:0] l);
    logic [111:0] nm;
    logic [111:0] o;
    logic         keep;
    nm   = {h, l};
    o    = '0;
    keep = 1'b1;
    for (int k = 0; k < 14; k++) begin
      keep = keep && (k < lacs_pkg::NAME_CHARS) && (nm[111-8*k -: 8] != 8'd0);
      if (keep) begin
        o[111-8*k -: 8] = nm[111-8*k -: 8];
      end
    end
    return o;
  endfunction

  assign nm_tidy   = tidy(in_name_high, in_name_low);
  assign it_in.cmd = lacs_pkg::cmd_t'(in_command);
  assign it_in.req = lacs_pkg::NODE_BITS'(in_requester);
  assign it_in.hi  = nm_tidy[111:56];
  assign it_in.lo  = nm_tidy[55:0];
  assign it_in.li  = in_lock_index;
  assign it_in.ci  = in_cond_index;

  assign full    = (cnt_r == 2'd2);
  assign acc     = push && !full;
  assign fr_vld  = (cnt_r != 2'd0);
  assign fr_item = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc) begin
        wp_r <= !wp_r;
      end
      if (fr_take) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(acc) - 2'(fr_take);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= it_in;
    end
  end

endmodule

// ----- sv/lacs_back.sv -----
// Back end: slot tables, wait queues and the request sequencer
`include "lock_and_condition_server_core_macros.svh"
module lacs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fr_vld,
  input  lacs_pkg::item_t fr_item,
  output logic            fr_take,
  output logic            empty,
  input  logic            pop,
  output lacs_pkg::res_t  out_res
);

  localparam int LW = $bits(lacs_pkg::lrow_t);
  localparam int CW = $bits(lacs_pkg::crow_t);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_SCAN = 6'b000100,
    S_CHK  = 6'b001000,
    S_FIN  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  lacs_pkg::item_t   it_r;
  logic [lacs_pkg::LB-1:0]  lrd_r;
  logic [lacs_pkg::CIB-1:0] crd_r;
  logic [lacs_pkg::LOCK_SLOTS-1:0] lvld_r;
  logic [lacs_pkg::COND_SLOTS-1:0] cvld_r;
  logic [lacs_pkg::SCAN_BITS-1:0] scan_r;
  logic                           free_have_r;
  logic [lacs_pkg::SCAN_BITS-1:0] free_idx_r;
  logic                           free_owned_r;
  logic [lacs_pkg::NODE_BITS-1:0] free_owner_r;
  logic                     wl_en_r, wc_en_r, lpop_r, cpop_r;
  logic [lacs_pkg::LB-1:0]  wl_addr_r;
  logic [lacs_pkg::CIB-1:0] wc_addr_r;
  lacs_pkg::lrow_t          wl_row_r;
  lacs_pkg::crow_t          wc_row_r;
  lacs_pkg::status_t        st_r;
  logic [6:0]               slot_r;
  lacs_pkg::res_t           res_r, out_r;
  logic                     out_vld_r;

  logic [LW-1:0] lram_q;
  logic [CW-1:0] cram_q;
  logic [lacs_pkg::LB-1:0]  lram_ra;
  logic [lacs_pkg::CIB-1:0] cram_ra;
  logic          lram_we, cram_we;
  lacs_pkg::lrow_t lr, fin_lrow;
  lacs_pkg::crow_t cr;
  logic [lacs_pkg::NODE_BITS-1:0] lwq_q, cwq_q;
  logic [lacs_pkg::LWA-1:0] lwq_wa, lwq_ra;
  logic [lacs_pkg::CWA-1:0] cwq_wa, cwq_ra;
  logic lwq_we, cwq_we;

  logic lok, cok, lused, is_create, name_empty;
  lacs_pkg::status_t e_st;
  lacs_pkg::lrow_t   e_nl;
  lacs_pkg::crow_t   e_nc;
  logic e_wl, e_wc, e_lpush, e_cpush, e_lpop, e_cpop;

  logic        c_lock, c_used, c_match, c_last, c_have;
  logic [55:0] c_hi, c_lo;
  logic [lacs_pkg::SCAN_BITS-1:0] c_idx;
  logic                           c_owned;
  logic [lacs_pkg::NODE_BITS-1:0] c_owner;

  function automatic logic [lacs_pkg::QB-1:0] qwrap(input logic [lacs_pkg::CNTB:0] s);
    logic [lacs_pkg::CNTB:0] d;
    d = (lacs_pkg::CNTB+1)'(lacs_pkg::QUEUE_DEPTH);
    return (s >= d) ? lacs_pkg::QB'(s - d) : lacs_pkg::QB'(s);
  endfunction

  function automatic logic [lacs_pkg::CNTB:0] qsum(input logic [lacs_pkg::QB-1:0] h,
                                                   input logic [lacs_pkg::CNTB-1:0] c);
    return (lacs_pkg::CNTB+1)'(h) + (lacs_pkg::CNTB+1)'(c);
  endfunction

  assign fr_take    = (state_r == S_IDLE) && fr_vld;
  assign is_create  = (fr_item.cmd == lacs_pkg::CMD_CREATE_LOCK) ||
                      (fr_item.cmd == lacs_pkg::CMD_CREATE_COND);
  assign name_empty = (fr_item.hi[55:48] == 8'd0);

  assign lram_ra = (state_r == S_SCAN) ? lacs_pkg::LB'(scan_r) : lacs_pkg::LB'(fr_item.li);
  assign cram_ra = (state_r == S_SCAN) ? lacs_pkg::CIB'(scan_r) : lacs_pkg::CIB'(fr_item.ci);

  assign lr = lvld_r[lrd_r] ? lacs_pkg::lrow_t'(lram_q) : '0;
  assign cr = cvld_r[crd_r] ? lacs_pkg::crow_t'(cram_q) : '0;

  always_comb begin
    fin_lrow = wl_row_r;
    if (lpop_r) begin
      fin_lrow.owner = lwq_q;
    end
  end

  assign lram_we = (state_r == S_FIN) && wl_en_r;
  assign cram_we = (state_r == S_FIN) && wc_en_r;

  lacs_ram #(.W(LW), .DEPTH(lacs_pkg::LOCK_SLOTS)) u_lram (
    .clk(clk), .we(lram_we), .waddr(wl_addr_r), .wdata(fin_lrow),
    .raddr(lram_ra), .rdata(lram_q)
  );

  lacs_ram #(.W(CW), .DEPTH(lacs_pkg::COND_SLOTS)) u_cram (
    .clk(clk), .we(cram_we), .waddr(wc_addr_r), .wdata(wc_row_r),
    .raddr(cram_ra), .rdata(cram_q)
  );

  assign lwq_we = (state_r == S_EXEC) && e_lpush;
  assign cwq_we = (state_r == S_EXEC) && e_cpush;
  assign lwq_wa = lacs_pkg::LWA'(lacs_pkg::LWA'(lacs_pkg::LB'(it_r.li)) *
                  lacs_pkg::LWA'(lacs_pkg::QUEUE_DEPTH) +
                  lacs_pkg::LWA'(qwrap(qsum(lr.head, lr.count))));
  assign lwq_ra = lacs_pkg::LWA'(lacs_pkg::LWA'(lacs_pkg::LB'(it_r.li)) *
                  lacs_pkg::LWA'(lacs_pkg::QUEUE_DEPTH) + lacs_pkg::LWA'(lr.head));
  assign cwq_wa = lacs_pkg::CWA'(lacs_pkg::CWA'(lacs_pkg::CIB'(it_r.ci)) *
                  lacs_pkg::CWA'(lacs_pkg::QUEUE_DEPTH) +
                  lacs_pkg::CWA'(qwrap(qsum(cr.head, cr.count))));
  assign cwq_ra = lacs_pkg::CWA'(lacs_pkg::CWA'(lacs_pkg::CIB'(it_r.ci)) *
                  lacs_pkg::CWA'(lacs_pkg::QUEUE_DEPTH) + lacs_pkg::CWA'(cr.head));

  lacs_ram #(.W(lacs_pkg::NODE_BITS), .DEPTH(lacs_pkg::LWQ_DEPTH)) u_lwq (
    .clk(clk), .we(lwq_we), .waddr(lwq_wa), .wdata(it_r.req),
    .raddr(lwq_ra), .rdata(lwq_q)
  );

  lacs_ram #(.W(lacs_pkg::NODE_BITS), .DEPTH(lacs_pkg::CWQ_DEPTH)) u_cwq (
    .clk(clk), .we(cwq_we), .waddr(cwq_wa), .wdata(it_r.req),
    .raddr(cwq_ra), .rdata(cwq_q)
  );

  assign lok   = (32'(it_r.li) < lacs_pkg::LOCK_SLOTS);
  assign cok   = (32'(it_r.ci) < lacs_pkg::COND_SLOTS);
  assign lused = (lr.hi[55:48] != 8'd0);

  always_comb begin
    e_st = lacs_pkg::ST_FAIL;
    e_nl = lr;
    e_nc = cr;
    e_wl = 1'b0;
    e_wc = 1'b0;
    e_lpush = 1'b0;
    e_cpush = 1'b0;
    e_lpop  = 1'b0;
    e_cpop  = 1'b0;
    case (it_r.cmd)
      lacs_pkg::CMD_DESTROY_LOCK: begin
        if (lok && (!lr.owned || lr.owner == it_r.req)) begin
          e_nl.hi    = '0;
          e_nl.lo    = '0;
          e_nl.owned = 1'b0;
          e_nl.owner = '0;
          e_wl = 1'b1;
          e_st = lacs_pkg::ST_OK;
        end
      end
      lacs_pkg::CMD_ACQUIRE: begin
        if (lok && lused) begin
          if (!lr.owned) begin
            e_nl.owned = 1'b1;
            e_nl.owner = it_r.req;
            e_wl = 1'b1;
            e_st = lacs_pkg::ST_OK;
          end else if (lr.owner == it_r.req) begin
            e_st = lacs_pkg::ST_OK;
          end else if (lr.count >= lacs_pkg::CNTB'(lacs_pkg::QUEUE_DEPTH)) begin
            e_st = lacs_pkg::ST_REFUSED;
          end else begin
            e_lpush    = 1'b1;
            e_nl.count = lacs_pkg::CNTB'(lr.count + 1'b1);
            e_wl = 1'b1;
            e_st = lacs_pkg::ST_WAIT;
          end
        end
      end
      lacs_pkg::CMD_RELEASE: begin
        if (lok && lused && !(lr.owned && lr.owner != it_r.req)) begin
          e_st = lacs_pkg::ST_OK;
          if (lr.owned) begin
            e_wl = 1'b1;
            if (lr.count != '0) begin
              e_lpop     = 1'b1;
              e_nl.head  = qwrap(qsum(lr.head, lacs_pkg::CNTB'(1)));
              e_nl.count = lacs_pkg::CNTB'(lr.count - 1'b1);
            end else begin
              e_nl.owned = 1'b0;
            end
          end
        end
      end
      lacs_pkg::CMD_DESTROY_COND: begin
        if (cok) begin
          e_nc.hi = '0;
          e_nc.lo = '0;
          e_wc = 1'b1;
          e_st = lacs_pkg::ST_OK;
        end
      end
      lacs_pkg::CMD_SIGNAL: begin
        if (lok && cok && lr.owned && lr.owner == it_r.req) begin
          e_st = lacs_pkg::ST_OK;
          if (cr.count != '0) begin
            e_cpop     = 1'b1;
            e_nc.head  = qwrap(qsum(cr.head, lacs_pkg::CNTB'(1)));
            e_nc.count = lacs_pkg::CNTB'(cr.count - 1'b1);
            e_wc = 1'b1;
          end
        end
      end
      lacs_pkg::CMD_WAIT: begin
        if (lok && cok && lr.owned && lr.owner == it_r.req) begin
          if (cr.count >= lacs_pkg::CNTB'(lacs_pkg::QUEUE_DEPTH)) begin
            e_st = lacs_pkg::ST_REFUSED;
          end else begin
            e_st       = lacs_pkg::ST_OK;
            e_cpush    = 1'b1;
            e_nc.count = lacs_pkg::CNTB'(cr.count + 1'b1);
            e_wc = 1'b1;
            e_wl = 1'b1;
            if (lr.count != '0) begin
              e_lpop     = 1'b1;
              e_nl.head  = qwrap(qsum(lr.head, lacs_pkg::CNTB'(1)));
              e_nl.count = lacs_pkg::CNTB'(lr.count - 1'b1);
            end else begin
              e_nl.owned = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign c_lock  = (it_r.cmd == lacs_pkg::CMD_CREATE_LOCK);
  assign c_hi    = c_lock ? lr.hi : cr.hi;
  assign c_lo    = c_lock ? lr.lo : cr.lo;
  assign c_used  = (c_hi[55:48] != 8'd0);
  assign c_match = c_used && (c_hi == it_r.hi) && (c_lo == it_r.lo);
  assign c_last  = c_lock ? (scan_r == lacs_pkg::SCAN_BITS'(lacs_pkg::LOCK_SLOTS - 1))
                          : (scan_r == lacs_pkg::SCAN_BITS'(lacs_pkg::COND_SLOTS - 1));
  assign c_have  = free_have_r || !c_used;
  assign c_idx   = free_have_r ? free_idx_r : scan_r;
  assign c_owned = free_have_r ? free_owned_r : lr.owned;
  assign c_owner = free_have_r ? free_owner_r : lr.owner;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (fr_vld) begin
          if (!is_create) begin
            state_nxt = S_EXEC;
          end else if (name_empty) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_EXEC: state_nxt = S_FIN;
      S_SCAN: state_nxt = S_CHK;
      S_CHK: begin
        if (c_match || c_last) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_FIN: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_vld_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      lvld_r    <= '0;
      cvld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (lram_we) begin
        lvld_r[wl_addr_r] <= 1'b1;
      end
      if (cram_we) begin
        cvld_r[wc_addr_r] <= 1'b1;
      end
      if ((state_r == S_DONE) && !out_vld_r) begin
        out_vld_r <= 1'b1;
      end else if (pop && out_vld_r) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lrd_r <= lram_ra;
    crd_r <= cram_ra;
    case (state_r)
      S_IDLE: begin
        if (fr_vld) begin
          it_r        <= fr_item;
          wl_en_r     <= 1'b0;
          wc_en_r     <= 1'b0;
          lpop_r      <= 1'b0;
          cpop_r      <= 1'b0;
          st_r        <= lacs_pkg::ST_FAIL;
          slot_r      <= 7'd0;
          scan_r      <= '0;
          free_have_r <= 1'b0;
        end
      end
      S_EXEC: begin
        st_r      <= e_st;
        wl_en_r   <= e_wl;
        wc_en_r   <= e_wc;
        wl_addr_r <= lacs_pkg::LB'(it_r.li);
        wc_addr_r <= lacs_pkg::CIB'(it_r.ci);
        wl_row_r  <= e_nl;
        wc_row_r  <= e_nc;
        lpop_r    <= e_lpop;
        cpop_r    <= e_cpop;
      end
      S_CHK: begin
        if (c_match) begin
          st_r   <= lacs_pkg::ST_OK;
          slot_r <= 7'(scan_r);
        end else begin
          if (!c_used && !free_have_r) begin
            free_have_r  <= 1'b1;
            free_idx_r   <= scan_r;
            free_owned_r <= lr.owned;
            free_owner_r <= lr.owner;
          end
          if (c_last) begin
            if (c_have) begin
              st_r   <= lacs_pkg::ST_OK;
              slot_r <= 7'(c_idx);
              wl_en_r <= c_lock;
              wc_en_r <= !c_lock;
              wl_addr_r <= lacs_pkg::LB'(c_idx);
              wc_addr_r <= lacs_pkg::CIB'(c_idx);
              wl_row_r.hi    <= it_r.hi;
              wl_row_r.lo    <= it_r.lo;
              wl_row_r.owned <= c_owned;
              wl_row_r.owner <= c_owner;
              wl_row_r.head  <= '0;
              wl_row_r.count <= '0;
              wc_row_r.hi    <= it_r.hi;
              wc_row_r.lo    <= it_r.lo;
              wc_row_r.head  <= '0;
              wc_row_r.count <= '0;
            end
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
      end
      S_FIN: begin
        res_r.status <= st_r;
        res_r.slot   <= slot_r;
        res_r.nv     <= lpop_r || cpop_r;
        res_r.nk     <= cpop_r ? lacs_pkg::KIND_COND : lacs_pkg::KIND_LOCK;
        res_r.nt     <= lpop_r ? 8'(lwq_q) : (cpop_r ? 8'(cwq_q) : 8'd0);
      end
      S_DONE: begin
        if (!out_vld_r) begin
          out_r <= res_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign empty   = !out_vld_r;
  assign out_res = out_r;

  `LACS_ASSERT(a_row_write_in_fin, (lram_we || cram_we) |-> (state_r == S_FIN), "row write outside finish step")
  `LACS_ASSERT_NEVER(a_two_pops, (state_r == S_FIN) && lpop_r && cpop_r, "both wait queues popped")
  `LACS_ASSERT(a_cond_notify, ((state_r == S_FIN) && cpop_r) |=> (res_r.nv && res_r.nk == lacs_pkg::KIND_COND), "wake-up not reported")
  `LACS_ASSERT(a_done_drains, ((state_r == S_DONE) && !out_vld_r) |=> (out_vld_r && state_r == S_IDLE), "result word not loaded")

endmodule

// ----- sv/lock_and_condition_server_core.sv -----
// Top level of the lock and condition server
//  channel  | handshake        | words
//  request  | push / full      | command, requester, name, lock and cond index
//  result   | empty / pop      | status, slot index, notification
// A request passes through the back-end steps IDLE, EXEC, FIN and DONE; a create with
// a non-empty name walks the slot table instead, with a SCAN and a CHK step per slot.
// The front queue holds two request words, so requests are taken while the
// back end works or a result word waits. Reset clears the slot valid bits;
// there is no clearing pass. The back end holds its finished result until
// the previous output word is taken.
module lock_and_condition_server_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_requester,
  input  logic [55:0] in_name_high,
  input  logic [55:0] in_name_low,
  input  logic [6:0]  in_lock_index,
  input  logic [6:0]  in_cond_index,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [6:0]  out_slot_index,
  output logic        out_notify_valid,
  output logic        out_notify_kind,
  output logic [7:0]  out_notify_target
);

  logic            fr_vld, fr_take;
  lacs_pkg::item_t fr_item;
  lacs_pkg::res_t  res;

  lacs_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_command(in_command), .in_requester(in_requester),
    .in_name_high(in_name_high), .in_name_low(in_name_low),
    .in_lock_index(in_lock_index), .in_cond_index(in_cond_index),
    .fr_vld(fr_vld), .fr_item(fr_item), .fr_take(fr_take)
  );

  lacs_back u_back (
    .clk(clk), .rst_n(rst_n), .fr_vld(fr_vld), .fr_item(fr_item),
    .fr_take(fr_take), .empty(empty), .pop(pop), .out_res(res)
  );

  assign out_status        = res.status;
  assign out_slot_index    = res.slot;
  assign out_notify_valid  = res.nv;
  assign out_notify_kind   = res.nk;
  assign out_notify_target = res.nt;

endmodule
